// ----- design/pls_pkg.sv -----
// Shared types and constants for the positional list store.
// No dependencies; every other design file refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;

    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RETRIEVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REPLACE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] FAILED_DELETE_VALUE = -32'sd404;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
    } result_t;

endpackage

`default_nettype wire

// ----- design/pls_req_if.sv -----
// Request and response channel interfaces for the positional list store.
// Depends on pls_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pls_req_if;
    logic                                      valid;
    logic                                      ready;
    logic [pls_pkg::ACT_W-1:0]                 action;
    logic [pls_pkg::POS_W-1:0]                 position;
    logic signed [pls_pkg::DATA_W-1:0]         value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink (input valid, input action, input position, input value,
                  output ready);
endinterface

interface pls_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic [pls_pkg::STAT_W-1:0]                status;
    logic signed [pls_pkg::DATA_W-1:0]         read_value;
    logic [pls_pkg::CNT_W-1:0]                 count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink (input valid, input status, input read_value, input count,
                  output ready);
endinterface

`default_nettype wire

// ----- design/positional_list_store_top.sv -----
// Sequence: replace, clear and failed requests go from the execute state straight to the result
//   register; retrieve, insert and delete pass through the shift and finish states first, and
//   shifts move one entry per cycle, set by the single write port of the entry memory.
// Throughput: one request at a time; the next is taken the cycle after the result is loaded.
// Reset: rst_n clears the sequencer, the element count and the result valid;
//   entries stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_top
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pls_req_if.sink    req,
    pls_rsp_if.source  rsp
);

    pls_pkg::request_t item;
    pls_pkg::result_t  core_result;
    pls_pkg::result_t  out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              core_idle;
    logic              core_done;
    logic              ack;
    logic              start;

    assign item.action   = req.action;
    assign item.position = req.position;
    assign item.value    = req.value;

    assign req.ready = core_idle;
    assign start     = req.valid && core_idle;

    // load the result register whenever it is empty or being emptied
    assign ack = core_done && (!out_valid_reg || rsp.ready);

    pls_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .idle   (core_idle),
        .done   (core_done),
        .ack    (ack),
        .result (core_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ack)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ack)
            out_reg <= core_result;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.count      = out_reg.count;

endmodule

`default_nettype wire

// ----- design/pls_core.sv -----
// Sequencer and entry memory of the positional list store.
// Depends on pls_pkg. One request at a time; shifts move one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pls_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pls_pkg::request_t item,
    output logic                   idle,
    output logic                   done,
    input  wire logic              ack,
    output pls_pkg::result_t       result
);

    localparam int AW = pls_pkg::ADDR_W;
    localparam int CW = pls_pkg::CNT_W;

    logic signed [pls_pkg::DATA_W-1:0] mem [pls_pkg::CAPACITY];

    pls_pkg::state_t state_reg, state_next;

    logic [pls_pkg::ACT_W-1:0]         action_reg;
    logic [pls_pkg::POS_W-1:0]         pos_reg;
    logic signed [pls_pkg::DATA_W-1:0] val_reg;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     src_reg, src_next;
    logic [AW-1:0]                     dst_reg, dst_next;
    logic [CW-1:0]                     left_reg, left_next;
    logic                              up_reg, up_next;
    logic                              pend_reg, pend_next;
    logic                              cap_reg, cap_next;
    logic [pls_pkg::STAT_W-1:0]        status_reg, status_next;
    logic signed [pls_pkg::DATA_W-1:0] rdval_reg, rdval_next;
    logic signed [pls_pkg::DATA_W-1:0] rdata_reg;

    logic [AW-1:0]                     raddr;
    logic                              we;
    logic [AW-1:0]                     waddr;
    logic signed [pls_pkg::DATA_W-1:0] wdata;

    logic          pos_gt_count;
    logic          pos_ge_count;
    logic          list_full;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] pos_cnt;
    logic [AW-1:0] pos_idx;

    assign pos_cnt      = CW'(pos_reg);
    assign pos_idx      = pos_reg[AW-1:0];
    assign pos_gt_count = pos_cnt > count_reg;
    assign pos_ge_count = pos_cnt >= count_reg;
    assign list_full    = count_reg == CW'(pls_pkg::CAPACITY);
    assign cnt_dec      = count_reg - CW'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (start)
                    state_next = pls_pkg::S_EXEC;
            end
            pls_pkg::S_EXEC:
            begin
                priority case (action_reg)
                    pls_pkg::ACT_INSERT:
                        state_next = (pos_gt_count || list_full) ? pls_pkg::S_DONE
                                                                 : pls_pkg::S_SHIFT;
                    pls_pkg::ACT_DELETE,
                    pls_pkg::ACT_RETRIEVE:
                        state_next = pos_ge_count ? pls_pkg::S_DONE : pls_pkg::S_SHIFT;
                    default:
                        state_next = pls_pkg::S_DONE;
                endcase
            end
            pls_pkg::S_SHIFT:
            begin
                if (left_reg == '0)
                    state_next = pls_pkg::S_FINISH;
            end
            pls_pkg::S_FINISH:
                state_next = pls_pkg::S_DONE;
            pls_pkg::S_DONE:
            begin
                if (ack)
                    state_next = pls_pkg::S_IDLE;
            end
            default:
                state_next = pls_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next  = count_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        left_next   = left_reg;
        up_next     = up_reg;
        pend_next   = pend_reg;
        cap_next    = cap_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        raddr       = src_reg;
        we          = 1'b0;
        waddr       = dst_reg;
        wdata       = rdata_reg;
        idle        = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            pls_pkg::S_IDLE:
                idle = 1'b1;
            pls_pkg::S_EXEC:
            begin
                status_next = pls_pkg::ST_OK;
                rdval_next  = '0;
                pend_next   = 1'b0;
                cap_next    = 1'b0;
                priority case (action_reg)
                    pls_pkg::ACT_INSERT:
                    begin
                        if (pos_gt_count)
                            status_next = pls_pkg::ST_RANGE;
                        else if (list_full)
                            status_next = pls_pkg::ST_FULL;
                        left_next = count_reg - pos_cnt;
                        src_next  = cnt_dec[AW-1:0];
                        up_next   = 1'b1;
                    end
                    pls_pkg::ACT_DELETE:
                    begin
                        if (pos_ge_count)
                        begin
                            status_next = pls_pkg::ST_RANGE;
                            rdval_next  = pls_pkg::FAILED_DELETE_VALUE;
                        end
                        // read the removed entry now, capture it next cycle
                        raddr     = pos_idx;
                        cap_next  = 1'b1;
                        left_next = cnt_dec - pos_cnt;
                        src_next  = pos_idx + AW'(1);
                        up_next   = 1'b0;
                    end
                    pls_pkg::ACT_RETRIEVE:
                    begin
                        if (pos_ge_count)
                            status_next = pls_pkg::ST_RANGE;
                        raddr     = pos_idx;
                        cap_next  = 1'b1;
                        left_next = '0;
                    end
                    pls_pkg::ACT_REPLACE:
                    begin
                        if (pos_ge_count)
                            status_next = pls_pkg::ST_RANGE;
                        else
                        begin
                            we    = 1'b1;
                            waddr = pos_idx;
                            wdata = val_reg;
                        end
                    end
                    pls_pkg::ACT_CLEAR:
                        count_next = '0;
                    default:
                        status_next = pls_pkg::ST_RANGE;
                endcase
            end
            pls_pkg::S_SHIFT:
            begin
                // drain the entry read last cycle while the next one is read
                we    = pend_reg;
                waddr = dst_reg;
                wdata = rdata_reg;
                if (cap_reg)
                begin
                    rdval_next = rdata_reg;
                    cap_next   = 1'b0;
                end
                raddr     = src_reg;
                pend_next = left_reg != '0;
                if (left_reg != '0)
                begin
                    left_next = left_reg - CW'(1);
                    dst_next  = up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                    src_next  = up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                end
            end
            pls_pkg::S_FINISH:
            begin
                if (action_reg == pls_pkg::ACT_INSERT)
                begin
                    we         = 1'b1;
                    waddr      = pos_idx;
                    wdata      = val_reg;
                    count_next = count_reg + CW'(1);
                end
                else if (action_reg == pls_pkg::ACT_DELETE)
                    count_next = cnt_dec;
            end
            pls_pkg::S_DONE:
                done = 1'b1;
            default:
                idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            cap_reg   <= 1'b0;
            up_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            cap_reg   <= cap_next;
            up_reg    <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == pls_pkg::S_IDLE)
        begin
            action_reg <= item.action;
            pos_reg    <= item.position;
            val_reg    <= item.value;
        end
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign result.status     = status_reg;
    assign result.read_value = rdval_reg;
    assign result.count      = count_reg;

endmodule

`default_nettype wire

// ----- design/pls_checker.sv -----
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and on positional_list_store_top.
`timescale 1ns / 1ps
`default_nettype none

module pls_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [pls_pkg::STAT_W-1:0]        rsp_status,
    input wire logic signed [pls_pkg::DATA_W-1:0] rsp_read_value,
    input wire logic [pls_pkg::CNT_W-1:0]         rsp_count
);

    // the block works on one request at a time
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("count above capacity");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == pls_pkg::ST_FULL
        |-> rsp_count == pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("full status with room left");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
        && $stable(rsp_status) && $stable(rsp_count))
        else $error("stalled response changed");

endmodule

bind positional_list_store_top pls_checker u_pls_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value),
    .rsp_count      (rsp.count)
);

`default_nettype wire
